/* src/gnl_pkg.sv */
// Shared types and constants for the lattice gradient noise block.
// Used by gnl_ctrl, gnl_dp and gradient_noise_lattice; no dependencies.
package gnl_pkg;

    // Table geometry and coordinate format (fixed by the item fields)
    localparam int TABLE_SIZE      = 256;
    localparam int IDX_W           = $clog2(TABLE_SIZE);
    localparam int COORD_FRAC_BITS = 16;
    localparam int NUM_AXES        = 4;

    // Item operation codes
    typedef enum logic [1:0] {
        OP_EVAL = 2'd0,
        OP_PERM = 2'd1,
        OP_GRAD = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_PERIODIC = 3'd0,
        CFG_PERIOD_X = 3'd1,
        CFG_PERIOD_Y = 3'd2,
        CFG_PERIOD_Z = 3'd3,
        CFG_PERIOD_W = 3'd4
    } t_cfg_idx;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_FIN,
        ST_HASH,
        ST_GRAD,
        ST_DOT,
        ST_CUR,
        ST_LCHK,
        ST_LMUL,
        ST_LADD,
        ST_OUT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic       capture;
        logic       perm_we;
        logic       grad_we;
        logic       mod_step;
        logic       sm_en;
        logic [1:0] sm_axis;
        logic       sm_phase;
        logic       mod_fin;
        logic       hash_rd;
        logic       grad_rd;
        logic       acc_clr;
        logic [1:0] k;
        logic [3:0] corner;
        logic       cur_load;
        logic       lvl_store;
        logic       lerp_mul;
        logic       lerp_add;
        logic [1:0] lvl_idx;
        logic       out_load;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

/* src/gradient_noise_lattice.sv */
// Top level of the lattice gradient noise block: controller plus datapath.
// Depends on gnl_pkg, gnl_ctrl and gnl_dp.
//
// Input channel (i_valid / o_stall): op 0 evaluates noise, op 1 writes a
// permutation entry, op 2 writes a gradient component, op 3 is dropped.
// Loads are written in the cycle they are accepted and give no result.
// An evaluate item runs through the 16-step remainder units, then per corner
// one permutation read per axis, one gradient read and MAC per axis, a MAC
// drain, a load and a level check, and per blend step a level check, a
// multiply on the shared lerp multiplier and an add, before its result is
// registered.
// One evaluate item is worked on at a time; o_stall is low again once the
// result has moved into the output register, so the next item may enter
// while that result still waits on o_valid / i_stall.
// If the receiver stalls and the output register is full, the finished
// result is held inside until the register frees.
// Configuration (i_cfg_valid / o_cfg_ready, always ready) sets periodic
// mode and the four axis periods; write it only while the block is idle.
// Reset (synchronous, active low) clears control state, the configuration
// registers and the output valid flag; the tables are undefined until loaded.
module gradient_noise_lattice (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_op,
    input  logic [2:0]         i_dims,
    input  logic [1:0]         i_table_sel,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_coord_z,
    input  logic signed [31:0] i_coord_w,
    input  logic [9:0]         i_load_addr,
    input  logic signed [15:0] i_load_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [15:0]        o_noise_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [8:0]         i_cfg_data
);
    import gnl_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    gnl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_op    (i_op),
        .i_dims  (i_dims),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    gnl_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_table_sel   (i_table_sel),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_coord_w     (i_coord_w),
        .i_load_addr   (i_load_addr),
        .i_load_data   (i_load_data),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_noise_value (o_noise_value)
    );

endmodule

/* src/gnl_ctrl.sv */
// Sequencer for the noise block: preparation, corner hashing, gradient
// dot products, blend tree and result hand-off. Depends on gnl_pkg.
module gnl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [1:0]    i_op,
    input  logic [2:0]    i_dims,
    output gnl_pkg::t_cmd o_cmd,
    input  gnl_pkg::t_sts i_sts
);
    import gnl_pkg::*;

    t_state     r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic [2:0] r_dims, n_dims;
    logic [1:0] r_k, n_k;
    logic [3:0] r_corner, n_corner;
    logic [2:0] r_lvl, n_lvl;
    logic       w_accept;
    logic       w_last_k;
    logic [2:0] w_dims_norm;

    assign w_accept = i_valid && (r_state == ST_IDLE);
    assign o_stall  = (r_state != ST_IDLE);
    assign w_last_k = ({1'b0, r_k} == (r_dims - 3'd1));

    // Out-of-range dimension counts clamp to 1..4
    always_comb begin
        if (i_dims inside {[3'd5:3'd7]}) begin
            w_dims_norm = 3'd4;
        end else if (i_dims == 3'd0) begin
            w_dims_norm = 3'd1;
        end else begin
            w_dims_norm = i_dims;
        end
    end

    // Next state and counters
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_dims   = r_dims;
        n_k      = r_k;
        n_corner = r_corner;
        n_lvl    = r_lvl;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (t_op'(i_op) == OP_EVAL)) begin
                    n_state = ST_PREP;
                    n_cnt   = 4'd0;
                    n_dims  = w_dims_norm;
                end
            end
            ST_PREP: begin
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_k      = 2'd0;
                n_corner = 4'd0;
                n_state  = ST_HASH;
            end
            ST_HASH: begin
                if (w_last_k) begin
                    n_k     = 2'd0;
                    n_state = ST_GRAD;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            ST_GRAD: begin
                if (w_last_k) begin
                    n_state = ST_DOT;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            ST_DOT: begin
                n_state = ST_CUR;
            end
            ST_CUR: begin
                n_lvl   = 3'd0;
                n_state = ST_LCHK;
            end
            ST_LCHK: begin
                if (r_lvl == r_dims) begin
                    n_state = ST_OUT;
                end else if (!r_corner[r_lvl[1:0]]) begin
                    n_corner = r_corner + 4'd1;
                    n_k      = 2'd0;
                    n_state  = ST_HASH;
                end else begin
                    n_state = ST_LMUL;
                end
            end
            ST_LMUL: begin
                n_state = ST_LADD;
            end
            ST_LADD: begin
                n_lvl   = r_lvl + 3'd1;
                n_state = ST_LCHK;
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd         = '0;
        o_cmd.k       = r_k;
        o_cmd.corner  = r_corner;
        o_cmd.lvl_idx = r_lvl[1:0];
        o_cmd.sm_axis = r_cnt[2:1];
        o_cmd.sm_phase = r_cnt[0];
        case (r_state)
            ST_IDLE: begin
                o_cmd.capture = w_accept && (t_op'(i_op) == OP_EVAL);
                o_cmd.perm_we = w_accept && (t_op'(i_op) == OP_PERM);
                o_cmd.grad_we = w_accept && (t_op'(i_op) == OP_GRAD);
            end
            ST_PREP: begin
                o_cmd.mod_step = 1'b1;
                o_cmd.sm_en    = !r_cnt[3];
            end
            ST_FIN:  o_cmd.mod_fin = 1'b1;
            ST_HASH: begin
                o_cmd.hash_rd = 1'b1;
                o_cmd.acc_clr = (r_k == 2'd0);
            end
            ST_GRAD: o_cmd.grad_rd = 1'b1;
            ST_CUR:  o_cmd.cur_load = 1'b1;
            ST_LCHK: o_cmd.lvl_store = (r_lvl != r_dims) && !r_corner[r_lvl[1:0]];
            ST_LMUL: o_cmd.lerp_mul = 1'b1;
            ST_LADD: o_cmd.lerp_add = 1'b1;
            ST_OUT:  o_cmd.out_load = i_sts.out_free;
            default: o_cmd.capture = 1'b0;
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= 4'd0;
            r_dims   <= 3'd1;
            r_k      <= 2'd0;
            r_corner <= 4'd0;
            r_lvl    <= 3'd0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_dims   <= n_dims;
            r_k      <= n_k;
            r_corner <= n_corner;
            r_lvl    <= n_lvl;
        end
    end

endmodule

/* src/gnl_dp.sv */
// Datapath of the noise block: tables, period registers, modulo units,
// smoothstep, dot-product MAC, blend stack and output register. Uses gnl_pkg.
module gnl_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gnl_pkg::t_cmd       i_cmd,
    output gnl_pkg::t_sts       o_sts,
    input  logic [1:0]          i_table_sel,
    input  logic signed [31:0]  i_coord_x,
    input  logic signed [31:0]  i_coord_y,
    input  logic signed [31:0]  i_coord_z,
    input  logic signed [31:0]  i_coord_w,
    input  logic [9:0]          i_load_addr,
    input  logic signed [15:0]  i_load_data,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [8:0]          i_cfg_data,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [15:0]         o_noise_value
);
    import gnl_pkg::*;

    // Tables
    logic [IDX_W-1:0]   r_perm_mem [0:3*TABLE_SIZE-1];
    logic signed [15:0] r_grad_mem [0:4*TABLE_SIZE-1];

    // Configuration
    logic       r_periodic;
    logic [8:0] r_period [NUM_AXES];

    // Per-axis preparation
    logic signed [31:0] w_coord   [NUM_AXES];
    logic [8:0]         w_p       [NUM_AXES];
    logic [9:0]         w_t       [NUM_AXES];
    logic [8:0]         w_rem_nx  [NUM_AXES];
    logic [8:0]         w_lo9     [NUM_AXES];
    logic [8:0]         w_hi9     [NUM_AXES];
    logic [1:0]         r_sel;
    logic [15:0]        r_frac    [NUM_AXES];
    logic [7:0]         r_cell_lo [NUM_AXES];
    logic               r_neg     [NUM_AXES];
    logic [15:0]        r_mag     [NUM_AXES];
    logic [8:0]         r_rem     [NUM_AXES];
    logic [7:0]         r_lo      [NUM_AXES];
    logic [7:0]         r_hi      [NUM_AXES];
    logic [15:0]        r_f2      [NUM_AXES];
    logic [16:0]        r_s       [NUM_AXES];

    // Smoothstep multiplier
    logic [17:0] w_sm_a, w_sm_b;
    logic [35:0] w_sm_prod;
    logic [15:0] w_sm_f;

    // Hash and MAC
    logic [7:0]         w_h, w_cv, w_idx;
    logic [7:0]         r_perm_q;
    logic signed [15:0] r_grad_q;
    logic               r_mac_en;
    logic signed [16:0] r_mac_off;
    logic signed [32:0] w_mac;
    logic signed [34:0] r_acc;

    // Blend stack
    logic signed [23:0] r_cur;
    logic signed [23:0] r_lvl [NUM_AXES];
    logic signed [23:0] w_lvl_a;
    logic signed [24:0] w_diff;
    logic signed [42:0] r_prod;

    // Output
    logic signed [23:0] w_half;
    logic signed [24:0] w_res;
    logic [15:0]        w_sat;
    logic               r_out_valid;
    logic [15:0]        r_out;

    assign w_coord[0] = i_coord_x;
    assign w_coord[1] = i_coord_y;
    assign w_coord[2] = i_coord_z;
    assign w_coord[3] = i_coord_w;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_periodic <= 1'b0;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_period[a] <= 9'd256;
            end
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PERIODIC: r_periodic  <= i_cfg_data[0];
                CFG_PERIOD_X: r_period[0] <= i_cfg_data;
                CFG_PERIOD_Y: r_period[1] <= i_cfg_data;
                CFG_PERIOD_Z: r_period[2] <= i_cfg_data;
                CFG_PERIOD_W: r_period[3] <= i_cfg_data;
                default:      r_periodic  <= r_periodic;
            endcase
        end
    end

    // Permutation table: tables 0..2 at {table, index}; table 3 writes dropped
    always_ff @(posedge i_clk) begin
        if (i_cmd.perm_we && (i_load_addr[9:8] != 2'd3)) begin
            r_perm_mem[i_load_addr] <= i_load_data[IDX_W-1:0];
        end
        if (i_cmd.hash_rd) begin
            r_perm_q <= r_perm_mem[{r_sel, w_idx}];
        end
    end

    // Gradient table
    always_ff @(posedge i_clk) begin
        if (i_cmd.grad_we) begin
            r_grad_mem[i_load_addr] <= i_load_data;
        end
        if (i_cmd.grad_rd) begin
            r_grad_q <= r_grad_mem[{r_perm_q, i_cmd.k}];
        end
    end

    // Restoring remainder step and final wrap, one unit per axis
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            w_p[a]   = (r_period[a] == 9'd0) ? 9'd1 : r_period[a];
            w_t[a]   = {r_rem[a], r_mag[a][15]};
            w_rem_nx[a] = (w_t[a] >= {1'b0, w_p[a]}) ? 9'(w_t[a] - {1'b0, w_p[a]})
                                                      : w_t[a][8:0];
            w_lo9[a] = (r_neg[a] && (r_rem[a] != 9'd0)) ? (w_p[a] - r_rem[a]) : r_rem[a];
            w_hi9[a] = (w_lo9[a] == (w_p[a] - 9'd1)) ? 9'd0 : (w_lo9[a] + 9'd1);
        end
    end

    // Shared smoothstep multiplier: f*f, then f2*(3-2f)
    assign w_sm_f    = r_frac[i_cmd.sm_axis];
    assign w_sm_a    = i_cmd.sm_phase ? (18'd196608 - {1'b0, w_sm_f, 1'b0})
                                      : {2'b00, w_sm_f};
    assign w_sm_b    = i_cmd.sm_phase ? {2'b00, r_f2[i_cmd.sm_axis]} : {2'b00, w_sm_f};
    assign w_sm_prod = w_sm_a * w_sm_b;

    // Capture, modulo iteration, smoothstep and wrap
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sel <= (i_table_sel == 2'd3) ? 2'd0 : i_table_sel;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_frac[a]    <= w_coord[a][15:0];
                r_cell_lo[a] <= w_coord[a][23:16];
                r_neg[a]     <= w_coord[a][31];
                r_mag[a]     <= w_coord[a][31] ? 16'(-w_coord[a][31:16])
                                               : w_coord[a][31:16];
                r_rem[a]     <= 9'd0;
            end
        end
        if (i_cmd.mod_step) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_rem[a] <= w_rem_nx[a];
                r_mag[a] <= {r_mag[a][14:0], 1'b0};
            end
        end
        if (i_cmd.sm_en) begin
            if (i_cmd.sm_phase) begin
                r_s[i_cmd.sm_axis] <= w_sm_prod[32:16];
            end else begin
                r_f2[i_cmd.sm_axis] <= w_sm_prod[31:16];
            end
        end
        if (i_cmd.mod_fin) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_lo[a] <= r_periodic ? w_lo9[a][7:0] : r_cell_lo[a];
                r_hi[a] <= r_periodic ? w_hi9[a][7:0] : (r_cell_lo[a] + 8'd1);
            end
        end
    end

    // Chained hash address: first axis starts from zero
    assign w_h   = (i_cmd.k == 2'd0) ? 8'd0 : r_perm_q;
    assign w_cv  = i_cmd.corner[i_cmd.k] ? r_hi[i_cmd.k] : r_lo[i_cmd.k];
    assign w_idx = w_h + w_cv;

    // Dot product MAC, one component per cycle
    assign w_mac = r_mac_off * r_grad_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac_en <= 1'b0;
        end else begin
            r_mac_en <= i_cmd.grad_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.grad_rd) begin
            r_mac_off <= {i_cmd.corner[i_cmd.k], r_frac[i_cmd.k]};
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_mac_en) begin
            r_acc <= r_acc + 35'(w_mac);
        end
    end

    // Blend stack: lerp along one axis per level
    assign w_lvl_a = r_lvl[i_cmd.lvl_idx];
    assign w_diff  = {r_cur[23], r_cur} - {w_lvl_a[23], w_lvl_a};

    always_ff @(posedge i_clk) begin
        if (i_cmd.cur_load) begin
            r_cur <= 24'($signed(r_acc[34:14]));
        end else if (i_cmd.lerp_add) begin
            r_cur <= w_lvl_a + r_prod[39:16];
        end
        if (i_cmd.lvl_store) begin
            r_lvl[i_cmd.lvl_idx] <= r_cur;
        end
        if (i_cmd.lerp_mul) begin
            r_prod <= $signed({1'b0, r_s[i_cmd.lvl_idx]}) * w_diff;
        end
    end

    // Map to 0.5 + 0.5*v and saturate
    assign w_half = r_cur >>> 1;
    assign w_res  = 25'sd32768 + 25'(w_half);
    always_comb begin
        if (w_res < 25'sd0) begin
            w_sat = 16'd0;
        end else if (w_res > 25'sd65535) begin
            w_sat = 16'hFFFF;
        end else begin
            w_sat = w_res[15:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= w_sat;
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_stall;
    assign o_valid        = r_out_valid;
    assign o_noise_value  = r_out;

endmodule

/* tb/tb_gradient_noise_lattice.sv */
// Self-checking testbench for gradient_noise_lattice: table loads, noise evaluation,
// periodic wrapping. Uses gnl_pkg for op codes and register indexes; needs only the RTL.
`timescale 1ns / 1ps

module tb_gradient_noise_lattice;
    import gnl_pkg::*;

    localparam int  SETTLE_CYCLES = 300;       // beyond the slowest 4-D evaluate
    localparam longint CYCLE_LIMIT = 6000000;

    typedef struct {
        t_op              op;
        logic [2:0]       dims;
        logic [1:0]       table_sel;
        logic [31:0]      coord [4];
        logic [9:0]       load_addr;
        logic [15:0]      load_data;
    } noise_item_t;

    // Noise predictor plus queue of expected noise values
    class noise_scoreboard;
        logic [7:0]         perm [3*TABLE_SIZE];
        logic signed [15:0] grad [4*TABLE_SIZE];
        bit                 periodic;
        logic [8:0]         period [4];
        logic [15:0]        noise_q [$];
        int                 failures;

        function void write_reg(t_cfg_idx idx, logic [8:0] d);
            case (idx)
                CFG_PERIODIC: periodic  = d[0];
                CFG_PERIOD_X: period[0] = d;
                CFG_PERIOD_Y: period[1] = d;
                CFG_PERIOD_Z: period[2] = d;
                CFG_PERIOD_W: period[3] = d;
                default: ;
            endcase
        endfunction

        function logic [15:0] noise_of(noise_item_t it);
            int     nd, sel, n, m;
            longint lat, p, fr, s2, dot, res, a, b;
            longint lo [4], hi [4], off0 [4], off1 [4], sm [4];
            longint val [16];
            logic [7:0] h;
            nd  = (it.dims == 0) ? 1 : ((it.dims > 4) ? 4 : int'(it.dims));
            sel = (it.table_sel == 2'd3) ? 0 : int'(it.table_sel);
            for (int k = 0; k < nd; k++) begin
                lat = longint'($signed(it.coord[k])) >>> COORD_FRAC_BITS;
                fr  = longint'(it.coord[k][15:0]);
                if (periodic) begin
                    p = (period[k] == 0) ? 1 : longint'(period[k]);
                    lat = lat % p;
                    if (lat < 0) lat += p;
                    hi[k] = (lat == p - 1) ? 0 : lat + 1;
                end else begin
                    hi[k] = lat + 1;
                end
                lo[k]   = lat;
                off0[k] = fr;
                off1[k] = fr - 65536;
                s2      = (fr * fr) >>> 16;
                sm[k]   = (s2 * (3*65536 - 2*fr)) >>> 16;
            end
            n = 1 << nd;
            for (int c = 0; c < n; c++) begin
                h   = 8'd0;
                dot = 0;
                for (int k = 0; k < nd; k++)
                    h = perm[sel*TABLE_SIZE +
                             int'((longint'(h) + (((c >> k) & 1) ? hi[k] : lo[k])) & 255)];
                for (int k = 0; k < nd; k++)
                    dot += (((c >> k) & 1) ? off1[k] : off0[k]) *
                           longint'(grad[int'(h)*4 + k]);
                val[c] = dot >>> 14;
            end
            // blend along x first, then y, z, w
            for (int k = 0; k < nd; k++) begin
                m = n >> (k + 1);
                for (int j = 0; j < m; j++) begin
                    a = val[2*j];
                    b = val[2*j+1];
                    val[j] = a + ((sm[k] * (b - a)) >>> 16);
                end
            end
            res = 32768 + (val[0] >>> 1);
            if (res < 0) res = 0;
            if (res > 65535) res = 65535;
            return 16'(res);
        endfunction

        function void note_input(noise_item_t it);
            case (it.op)
                OP_PERM: if (it.load_addr < 10'(3*TABLE_SIZE))
                    perm[it.load_addr] = it.load_data[7:0];
                OP_GRAD: grad[it.load_addr] = $signed(it.load_data);
                OP_EVAL: noise_q.push_back(noise_of(it));
                default: ;
            endcase
        endfunction

        function void check_result(logic [15:0] got);
            logic [15:0] want;
            if (noise_q.size() == 0) begin
                failures++;
                if (failures <= 10) $display("unexpected result: noise %0d", got);
                return;
            end
            want = noise_q.pop_front();
            if (got !== want) begin
                failures++;
                if (failures <= 10)
                    $display("noise mismatch: expected %0d, got %0d", want, got);
            end
        endfunction
    endclass

    logic               i_clk, i_rst_n;
    logic               i_valid, o_stall;
    logic [1:0]         i_op;
    logic [2:0]         i_dims;
    logic [1:0]         i_table_sel;
    logic signed [31:0] i_coord_x, i_coord_y, i_coord_z, i_coord_w;
    logic [9:0]         i_load_addr;
    logic signed [15:0] i_load_data;
    logic               o_valid, i_stall;
    logic [15:0]        o_noise_value;
    logic               i_cfg_valid, o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [8:0]         i_cfg_data;

    noise_scoreboard sb;
    bit              calm;
    int              stall_left;
    longint          cycles;

    gradient_noise_lattice dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver stalls in random bursts
    always @(posedge i_clk) begin
        if (calm) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 6);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // note accepted items and check results
    always @(posedge i_clk) begin
        noise_item_t it;
        if (i_rst_n && i_valid && !o_stall) begin
            it.op        = t_op'(i_op);
            it.dims      = i_dims;
            it.table_sel = i_table_sel;
            it.coord[0]  = i_coord_x;
            it.coord[1]  = i_coord_y;
            it.coord[2]  = i_coord_z;
            it.coord[3]  = i_coord_w;
            it.load_addr = i_load_addr;
            it.load_data = i_load_data;
            sb.note_input(it);
        end
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_noise_value);
    end

    task automatic send_item(noise_item_t it);
        i_valid     <= 1'b1;
        i_op        <= it.op;
        i_dims      <= it.dims;
        i_table_sel <= it.table_sel;
        i_coord_x   <= it.coord[0];
        i_coord_y   <= it.coord[1];
        i_coord_z   <= it.coord[2];
        i_coord_w   <= it.coord[3];
        i_load_addr <= it.load_addr;
        i_load_data <= it.load_data;
        do @(posedge i_clk); while (o_stall);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic set_reg(t_cfg_idx idx, logic [8:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.write_reg(idx, d);
    endtask

    task automatic set_periods(logic [8:0] px, logic [8:0] py, logic [8:0] pz,
                               logic [8:0] pw);
        set_reg(CFG_PERIOD_X, px);
        set_reg(CFG_PERIOD_Y, py);
        set_reg(CFG_PERIOD_Z, pz);
        set_reg(CFG_PERIOD_W, pw);
    endtask

    // let every evaluate finish before touching the registers
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.noise_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic noise_item_t random_item();
        noise_item_t it;
        int          r;
        r = $urandom_range(0, 99);
        it.op        = (r < 55) ? OP_EVAL : (r < 75) ? OP_PERM : (r < 95) ? OP_GRAD : OP_NONE;
        // mostly small dimension counts keep the run short
        r = $urandom_range(0, 9);
        it.dims      = (r < 4) ? 3'(r % 3 + 1) : (r < 8) ? 3'($urandom_range(0, 7)) : 3'd4;
        it.table_sel = 2'($urandom_range(0, 3));
        for (int k = 0; k < 4; k++) begin
            it.coord[k] = $urandom;
            if ($urandom_range(0, 2) == 0)
                it.coord[k][31:16] = 16'($signed($urandom_range(0, 15)) - 8);
        end
        it.load_addr = 10'($urandom);
        it.load_data = 16'($urandom);
        return it;
    endfunction

    function automatic noise_item_t eval_item(logic [2:0] d, logic [1:0] sel,
                                              logic [31:0] c);
        noise_item_t it;
        it = random_item();
        it.op        = OP_EVAL;
        it.dims      = d;
        it.table_sel = sel;
        for (int k = 0; k < 4; k++) it.coord[k] = (k == 0) ? c : $urandom;
        return it;
    endfunction

    initial begin
        noise_item_t it;
        sb = new();
        sb.periodic = 1'b0;
        for (int k = 0; k < 4; k++) sb.period[k] = 9'd256;
        calm        = 1'b0;
        stall_left  = 0;
        cycles      = 0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_stall     = 1'b0;
        i_op        = OP_NONE;
        i_dims      = '0;
        i_table_sel = '0;
        i_coord_x   = '0;
        i_coord_y   = '0;
        i_coord_z   = '0;
        i_coord_w   = '0;
        i_load_addr = '0;
        i_load_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_PERIODIC;
        i_cfg_data  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill every table entry so no evaluate reads an unwritten one
        for (int a = 0; a < 3*TABLE_SIZE; a++) begin
            it = random_item();
            it.op = OP_PERM;
            it.load_addr = 10'(a);
            send_item(it);
        end
        for (int a = 0; a < 4*TABLE_SIZE; a++) begin
            it = random_item();
            it.op = OP_GRAD;
            it.load_addr = 10'(a);
            send_item(it);
        end

        // directed: coordinate extremes, dims and table choice out of range
        send_item(eval_item(3'd1, 2'd0, 32'h0000_0000));
        send_item(eval_item(3'd1, 2'd1, 32'h7FFF_FFFF));
        send_item(eval_item(3'd2, 2'd2, 32'h8000_0000));
        send_item(eval_item(3'd3, 2'd3, 32'hFFFF_FFFF));
        send_item(eval_item(3'd4, 2'd0, 32'h0000_FFFF));
        send_item(eval_item(3'd0, 2'd1, 32'h0001_8000));
        send_item(eval_item(3'd5, 2'd2, 32'hFFFF_0000));
        send_item(eval_item(3'd7, 2'd3, 32'h1234_5678));
        it = random_item(); it.op = OP_NONE; send_item(it);
        // perm write beyond the third table is dropped
        it = random_item(); it.op = OP_PERM; it.load_addr = 10'd900; send_item(it);
        it = random_item(); it.op = OP_GRAD; it.load_addr = 10'd1023;
        it.load_data = 16'h8000; send_item(it);
        it = random_item(); it.op = OP_GRAD; it.load_addr = 10'd0;
        it.load_data = 16'h7FFF; send_item(it);
        send_item(eval_item(3'd1, 2'd0, 32'h0000_0001));

        // periodic mode with extreme periods, zero acting as one
        drain();
        set_reg(CFG_PERIODIC, 9'd1);
        set_periods(9'd1, 9'd256, 9'd0, 9'd511);
        send_item(eval_item(3'd4, 2'd0, 32'hFFFF_FFFF));
        send_item(eval_item(3'd2, 2'd1, 32'h7FFF_0000));
        send_item(eval_item(3'd3, 2'd2, 32'h8000_8000));
        repeat (300) send_item(random_item());

        // periodic mode with random periods
        drain();
        set_periods(9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)),
                    9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)));
        repeat (300) send_item(random_item());

        drain();
        set_periods(9'd2, 9'd255, 9'd3, 9'd256);
        repeat (250) send_item(random_item());

        // back to plain mode; last stretch with no idling
        drain();
        set_reg(CFG_PERIODIC, 9'd0);
        set_periods(9'd256, 9'd256, 9'd256, 9'd256);
        repeat (200) send_item(random_item());
        calm = 1'b1;
        repeat (200) send_item(random_item());

        drain();
        if (sb.failures == 0 && sb.noise_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* gradient_noise_lattice.f */
src/gnl_pkg.sv
src/gnl_ctrl.sv
src/gnl_dp.sv
src/gradient_noise_lattice.sv
tb/tb_gradient_noise_lattice.sv
